[src/sparse_matrix_store_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef SPARSE_MATRIX_STORE_CORE_DEFINES_SVH
`define SPARSE_MATRIX_STORE_CORE_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define SMS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, gated by reset.
`define SMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/sms_pkg.sv]
// ----------------------------------------------------------------------------
// sms_pkg
// Types and constants of the sparse matrix store.
// ----------------------------------------------------------------------------
package sms_pkg;

  localparam int CAPACITY     = 64;
  localparam int INDEX_BITS   = 8;
  localparam int VALUE_BITS   = 32;
  localparam int SLOT_BITS    = $clog2(CAPACITY);
  localparam int CNT_BITS     = $clog2(CAPACITY + 1);
  localparam int PROD_BITS    = 2 * INDEX_BITS;
  localparam int TOT_BITS     = 2 * INDEX_BITS + 2;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLUMN_COUNT = 1'd1;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_SET_DEF  = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef struct packed {
    logic cell_hit;
    logic val_hit;
    logic in_rng;
  } match_t;

endpackage

[src/sms_ram.sv]
// ----------------------------------------------------------------------------
// sms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[src/sms_match.sv]
// ----------------------------------------------------------------------------
// sms_match
// Shared compare unit: one table entry against the search key and dims.
// ----------------------------------------------------------------------------
module sms_match (
  input  sms_pkg::entry_t                  ent,
  input  logic [sms_pkg::INDEX_BITS-1:0]   key_row,
  input  logic [sms_pkg::INDEX_BITS-1:0]   key_col,
  input  logic [sms_pkg::VALUE_BITS-1:0]   key_val,
  input  logic [sms_pkg::INDEX_BITS-1:0]   row_count,
  input  logic [sms_pkg::INDEX_BITS-1:0]   col_count,
  output sms_pkg::match_t                  m
);

  always_comb begin
    m.cell_hit = (ent.row == key_row) && (ent.col == key_col);
    m.val_hit  = (ent.value == key_val);
    m.in_rng   = (ent.row != '0) && (ent.row <= row_count) &&
                 (ent.col != '0) && (ent.col <= col_count);
  end

endmodule

[src/sparse_matrix_store_core.sv]
// A write runs a full table scan and an apply step before its result beat; read and
// contains run one full table scan; an out-of-range write or read skips the scan.
// Set-default runs one scan when no entry holds the new value; otherwise two
// scans plus one scan and one insert step per in-range cell (R*C), unless it would overflow.
// Throughput: one item at a time, bound by the table scan through the single read port.
// Reset (rst_n low, synchronous) clears dims, default, valid bits and count.
// ----------------------------------------------------------------------------
// sparse_matrix_store_core
// Coordinate-list sparse matrix: a 64-slot table scanned one slot per cycle
// through a shared compare unit under a small sequencer.
// ----------------------------------------------------------------------------
module sparse_matrix_store_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input beats
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            in_op,
  input  logic [sms_pkg::INDEX_BITS-1:0]        in_row,
  input  logic [sms_pkg::INDEX_BITS-1:0]        in_col,
  input  logic signed [sms_pkg::VALUE_BITS-1:0] in_value,
  // result beats
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sms_pkg::VALUE_BITS-1:0] out_read_value,
  output logic                                  out_present,
  output logic [1:0]                            out_status,
  output logic [sms_pkg::CNT_BITS-1:0]          out_entry_count,
  // register writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sms_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [sms_pkg::INDEX_BITS-1:0]        cfg_data
);

  localparam logic [sms_pkg::CNT_BITS-1:0] CAP_CNT = sms_pkg::CNT_BITS'(sms_pkg::CAPACITY);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_CALC  = 6'b000100,
    S_CHECK = 6'b001000,
    S_APPLY = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // what the current scan is for
  typedef enum logic [2:0] {
    PH_LOOK   = 3'b001,
    PH_REMOVE = 3'b010,
    PH_CELL   = 3'b100
  } phase_t;

  state_t state_r, state_nxt;
  phase_t ph_r, ph_nxt;

  logic [sms_pkg::INDEX_BITS-1:0] rows_r, rows_nxt, cols_r, cols_nxt;
  logic [sms_pkg::VALUE_BITS-1:0] def_r, def_nxt;
  logic [sms_pkg::CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                           vld_r [sms_pkg::CAPACITY];
  logic                           vld_nxt [sms_pkg::CAPACITY];

  // captured item
  sms_pkg::op_t                   op_r, op_nxt;
  logic [sms_pkg::INDEX_BITS-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [sms_pkg::VALUE_BITS-1:0] val_r, val_nxt;

  // scan sequencer
  logic [sms_pkg::CNT_BITS-1:0]   scan_r, scan_nxt;
  logic                           pend_r, pend_nxt;
  logic [sms_pkg::SLOT_BITS-1:0]  pidx_r, pidx_nxt;

  // scan results
  logic                           hit_r, hit_nxt;
  logic [sms_pkg::SLOT_BITS-1:0]  hslot_r, hslot_nxt;
  logic [sms_pkg::VALUE_BITS-1:0] hval_r, hval_nxt;
  logic                           free_r, free_nxt;
  logic [sms_pkg::SLOT_BITS-1:0]  fslot_r, fslot_nxt;
  logic                           vhit_r, vhit_nxt;
  logic [sms_pkg::CNT_BITS-1:0]   inside_r, inside_nxt, match_r, match_nxt;

  // set-default rebuild
  logic [sms_pkg::PROD_BITS-1:0]  prod_r, prod_nxt;
  logic [sms_pkg::INDEX_BITS-1:0] cr_r, cr_nxt, cc_r, cc_nxt;

  // result being built and the output register
  logic [sms_pkg::VALUE_BITS-1:0] rv_r, rv_nxt;
  logic                           pres_r, pres_nxt;
  logic [1:0]                     stat_r, stat_nxt;
  logic                           ov_r, ov_nxt;
  logic [sms_pkg::VALUE_BITS-1:0] o_rv_r, o_rv_nxt;
  logic                           o_pres_r, o_pres_nxt;
  logic [1:0]                     o_stat_r, o_stat_nxt;
  logic [sms_pkg::CNT_BITS-1:0]   o_cnt_r, o_cnt_nxt;

  // table memory
  logic                           ram_we;
  logic [sms_pkg::SLOT_BITS-1:0]  ram_waddr, ram_raddr;
  sms_pkg::entry_t                ram_wdata, ram_rdata;

  logic [sms_pkg::INDEX_BITS-1:0] key_row, key_col;
  sms_pkg::match_t                mres;
  logic                           start_scan;
  logic                           in_rng_in;
  logic [sms_pkg::TOT_BITS-1:0]   total;

  sms_ram #(
    .WIDTH (sms_pkg::ENTRY_BITS),
    .DEPTH (sms_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // the rebuild walk searches the walked cell, everything else the item's cell
  assign key_row = (ph_r == PH_CELL) ? cr_r : row_r;
  assign key_col = (ph_r == PH_CELL) ? cc_r : col_r;

  sms_match u_match (
    .ent       (ram_rdata),
    .key_row   (key_row),
    .key_col   (key_col),
    .key_val   (val_r),
    .row_count (rows_r),
    .col_count (cols_r),
    .m         (mres)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid       = ov_r;
  assign out_read_value  = o_rv_r;
  assign out_present     = o_pres_r;
  assign out_status      = o_stat_r;
  assign out_entry_count = o_cnt_r;

  assign in_rng_in = (in_row != '0) && (in_row <= rows_r) &&
                     (in_col != '0) && (in_col <= cols_r);

  // cells in range minus those already held, plus survivors of the removal
  assign total = sms_pkg::TOT_BITS'(cnt_r) - sms_pkg::TOT_BITS'(match_r) +
                 sms_pkg::TOT_BITS'(prod_r) - sms_pkg::TOT_BITS'(inside_r);

  always_comb begin
    state_nxt = state_r;  ph_nxt = ph_r;
    rows_nxt = rows_r;    cols_nxt = cols_r;
    def_nxt = def_r;      cnt_nxt = cnt_r;
    vld_nxt = vld_r;
    op_nxt = op_r;  row_nxt = row_r;  col_nxt = col_r;  val_nxt = val_r;
    scan_nxt = scan_r;  pend_nxt = pend_r;  pidx_nxt = pidx_r;
    hit_nxt = hit_r;  hslot_nxt = hslot_r;  hval_nxt = hval_r;
    free_nxt = free_r;  fslot_nxt = fslot_r;  vhit_nxt = vhit_r;
    inside_nxt = inside_r;  match_nxt = match_r;
    prod_nxt = prod_r;  cr_nxt = cr_r;  cc_nxt = cc_r;
    rv_nxt = rv_r;  pres_nxt = pres_r;  stat_nxt = stat_r;
    ov_nxt = ov_r;  o_rv_nxt = o_rv_r;  o_pres_nxt = o_pres_r;
    o_stat_nxt = o_stat_r;  o_cnt_nxt = o_cnt_r;
    ram_we = 1'b0;  ram_waddr = '0;  ram_wdata = '0;
    ram_raddr = scan_r[sms_pkg::SLOT_BITS-1:0];
    start_scan = 1'b0;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sms_pkg::REG_ROW_COUNT:    rows_nxt = cfg_data;
        sms_pkg::REG_COLUMN_COUNT: cols_nxt = cfg_data;
        default: ;
      endcase
    end

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt  = sms_pkg::op_t'(in_op);
          row_nxt = in_row;
          col_nxt = in_col;
          val_nxt = in_value;
          rv_nxt = '0;  pres_nxt = 1'b0;  stat_nxt = sms_pkg::ST_OK;
          ph_nxt = PH_LOOK;
          if ((in_op == sms_pkg::OP_WRITE || in_op == sms_pkg::OP_READ) && !in_rng_in) begin
            stat_nxt  = sms_pkg::ST_RANGE;
            state_nxt = S_DONE;
          end else begin
            start_scan = 1'b1;
            state_nxt  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // evaluate the slot read last cycle
        if (pend_r) begin
          if (!vld_r[pidx_r]) begin
            if (!free_r) begin
              free_nxt  = 1'b1;
              fslot_nxt = pidx_r;
            end
          end else begin
            if (mres.cell_hit && !hit_r) begin
              hit_nxt   = 1'b1;
              hslot_nxt = pidx_r;
              hval_nxt  = ram_rdata.value;
            end
            if (mres.val_hit) begin
              vhit_nxt  = 1'b1;
              match_nxt = match_r + 1'b1;
              if (ph_r == PH_REMOVE) begin
                vld_nxt[pidx_r] = 1'b0;
                cnt_nxt = cnt_nxt - 1'b1;
              end
            end
            if (mres.in_rng) begin
              inside_nxt = inside_r + 1'b1;
            end
          end
        end
        // issue the next read
        if (scan_r != CAP_CNT) begin
          pidx_nxt = scan_r[sms_pkg::SLOT_BITS-1:0];
          pend_nxt = 1'b1;
          scan_nxt = scan_r + 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (scan_r == CAP_CNT && !pend_r) begin
          case (ph_r)
            PH_LOOK: begin
              case (op_r)
                sms_pkg::OP_WRITE: state_nxt = S_APPLY;
                sms_pkg::OP_READ: begin
                  rv_nxt    = hit_r ? hval_r : def_r;
                  state_nxt = S_DONE;
                end
                sms_pkg::OP_CONTAINS: begin
                  pres_nxt  = vhit_r;
                  state_nxt = S_DONE;
                end
                default: begin
                  if (!vhit_r) begin
                    def_nxt   = val_r;
                    state_nxt = S_DONE;
                  end else begin
                    state_nxt = S_CALC;
                  end
                end
              endcase
            end
            PH_REMOVE: begin
              if (rows_r == '0 || cols_r == '0) begin
                def_nxt   = val_r;
                state_nxt = S_DONE;
              end else begin
                cr_nxt = sms_pkg::INDEX_BITS'(1);
                cc_nxt = sms_pkg::INDEX_BITS'(1);
                ph_nxt = PH_CELL;
                start_scan = 1'b1;
              end
            end
            default: state_nxt = S_APPLY;
          endcase
        end
      end

      S_CALC: begin
        prod_nxt  = rows_r * cols_r;
        state_nxt = S_CHECK;
      end

      S_CHECK: begin
        if (total > sms_pkg::TOT_BITS'(sms_pkg::CAPACITY)) begin
          stat_nxt  = sms_pkg::ST_FULL;
          state_nxt = S_DONE;
        end else begin
          ph_nxt     = PH_REMOVE;
          start_scan = 1'b1;
          state_nxt  = S_SCAN;
        end
      end

      S_APPLY: begin
        if (ph_r == PH_CELL) begin
          // fill an absent cell with the old default
          if (!hit_r && free_r) begin
            ram_we    = 1'b1;
            ram_waddr = fslot_r;
            ram_wdata = '{row: cr_r, col: cc_r, value: def_r};
            vld_nxt[fslot_r] = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
          if (cc_r == cols_r) begin
            if (cr_r == rows_r) begin
              def_nxt   = val_r;
              state_nxt = S_DONE;
            end else begin
              cr_nxt = cr_r + 1'b1;
              cc_nxt = sms_pkg::INDEX_BITS'(1);
              start_scan = 1'b1;
              state_nxt  = S_SCAN;
            end
          end else begin
            cc_nxt = cc_r + 1'b1;
            start_scan = 1'b1;
            state_nxt  = S_SCAN;
          end
        end else begin
          // cell write
          if (hit_r) begin
            if (val_r == def_r) begin
              vld_nxt[hslot_r] = 1'b0;
              cnt_nxt = cnt_r - 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = hslot_r;
              ram_wdata = '{row: row_r, col: col_r, value: val_r};
            end
          end else if (val_r != def_r) begin
            if (free_r) begin
              ram_we    = 1'b1;
              ram_waddr = fslot_r;
              ram_wdata = '{row: row_r, col: col_r, value: val_r};
              vld_nxt[fslot_r] = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              stat_nxt = sms_pkg::ST_FULL;
            end
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt     = 1'b1;
          o_rv_nxt   = rv_r;
          o_pres_nxt = pres_r;
          o_stat_nxt = stat_r;
          o_cnt_nxt  = cnt_r;
          state_nxt  = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (start_scan) begin
      scan_nxt = '0;  pend_nxt = 1'b0;
      hit_nxt = 1'b0;  free_nxt = 1'b0;  vhit_nxt = 1'b0;
      inside_nxt = '0;  match_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= PH_LOOK;
      rows_r  <= '0;
      cols_r  <= '0;
      def_r   <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      scan_r  <= '0;
      for (int i = 0; i < sms_pkg::CAPACITY; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      rows_r  <= rows_nxt;
      cols_r  <= cols_nxt;
      def_r   <= def_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
      scan_r  <= scan_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;  row_r <= row_nxt;  col_r <= col_nxt;  val_r <= val_nxt;
    pidx_r <= pidx_nxt;
    hit_r <= hit_nxt;  hslot_r <= hslot_nxt;  hval_r <= hval_nxt;
    free_r <= free_nxt;  fslot_r <= fslot_nxt;  vhit_r <= vhit_nxt;
    inside_r <= inside_nxt;  match_r <= match_nxt;
    prod_r <= prod_nxt;  cr_r <= cr_nxt;  cc_r <= cc_nxt;
    rv_r <= rv_nxt;  pres_r <= pres_nxt;  stat_r <= stat_nxt;
    o_rv_r <= o_rv_nxt;  o_pres_r <= o_pres_nxt;
    o_stat_r <= o_stat_nxt;  o_cnt_r <= o_cnt_nxt;
  end

endmodule

[src/sms_chk.sv]
// ----------------------------------------------------------------------------
// sms_chk
// Port-level checks of the sparse matrix store, bound to the top level.
// ----------------------------------------------------------------------------
`include "sparse_matrix_store_core_defines.svh"

module sms_chk (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [sms_pkg::VALUE_BITS-1:0] out_read_value,
  input logic                                  out_present,
  input logic [1:0]                            out_status,
  input logic [sms_pkg::CNT_BITS-1:0]          out_entry_count
);

  // the block is busy in the cycle after an accepted beat
  `SMS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  // status codes stop at store full
  `SMS_ASSERT_IMPL(a_status_code, out_valid, out_status <= sms_pkg::ST_FULL, "bad status code")
  // count never exceeds the table size
  `SMS_ASSERT_IMPL(a_count_cap, out_valid,
    out_entry_count <= sms_pkg::CNT_BITS'(sms_pkg::CAPACITY), "count above capacity")
  // a found value only comes with an ok status
  `SMS_ASSERT_IMPL(a_present_ok, out_valid && out_present,
    out_status == sms_pkg::ST_OK, "present with error status")
  // a stalled result beat holds
  `SMS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_read_value), "stalled result changed")

endmodule

bind sparse_matrix_store_core sms_chk u_sms_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_read_value  (out_read_value),
  .out_present     (out_present),
  .out_status      (out_status),
  .out_entry_count (out_entry_count)
);
